// ----- sv/fjd_pkg.sv -----
// Shared types and constants for the job dispatcher.
// Used by fjd_front, fjd_back, the top level and fjd_checker; no dependencies.
package fjd_pkg;

  localparam int ACTION_W = 2;
  localparam int KIND_W   = 2;
  localparam int JOB_ID_W = 31;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 16;
  localparam int END_W    = 33;
  localparam int TOTAL_W  = 48;
  localparam int WORKER_W = 3;

  // action codes (slave tuser)
  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPORT  = 2'd2;

  // result kinds (master tuser)
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd2;

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // one job, job_id in the lowest bits
  typedef struct packed {
    logic [DUR_W-1:0]    service_time;
    logic [TIME_W-1:0]   arrival_time;
    logic [JOB_ID_W-1:0] job_id;
  } job_t;

  // slave tdata layout, padded to 80 bits
  typedef struct packed {
    logic pad;
    job_t job;
  } in_data_t;

  // master tdata layout, padded to 184 bits
  typedef struct packed {
    logic [3:0]          pad;
    logic [TOTAL_W-1:0]  total_service;
    logic [TIME_W-1:0]   wait_time;
    logic [END_W-1:0]    end_time;
    logic [TIME_W-1:0]   start_time;
    logic [WORKER_W-1:0] worker_number;
    logic [JOB_ID_W-1:0] out_job_id;
    logic                accepted;
  } out_data_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    job_t                job;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last;
    out_data_t         data;
  } result_t;

endpackage

// ----- sv/fjd_front.sv -----
// Front end of the job dispatcher: accepts stream transactions, drops unknown
// actions and queues commands in a two-entry queue. Depends on fjd_pkg.
module fjd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [79:0]                   s_tdata,   // job_id, arrival_time, service_time
  input  logic [fjd_pkg::ACTION_W-1:0]  s_tuser,   // action
  output logic                          cmd_valid,
  output fjd_pkg::cmd_t                 cmd,
  input  logic                          cmd_ready
);

  fjd_pkg::cmd_t     slot [2];
  fjd_pkg::in_data_t in_data;
  logic [1:0]        fill;
  logic              wr_ptr;
  logic              rd_ptr;
  logic              known;
  logic              push;
  logic              pop;

  assign in_data   = s_tdata;
  assign known     = (s_tuser == fjd_pkg::ACT_ENQUEUE) || (s_tuser == fjd_pkg::ACT_TICK) ||
                     (s_tuser == fjd_pkg::ACT_REPORT);
  assign s_tready  = (fill != 2'd2);
  assign push      = s_tvalid && s_tready && known;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{action: s_tuser, job: in_data.job};
    end
  end

endmodule

// ----- sv/fjd_back.sv -----
// Back end of the job dispatcher: job store, free-worker stack, worker table,
// time base and result register. Depends on fjd_pkg.
module fjd_back #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int WORKER_COUNT = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  fjd_pkg::cmd_t               cmd,
  output logic                        cmd_ready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [183:0]                m_tdata,
  output logic [fjd_pkg::KIND_W-1:0]  m_tuser,
  output logic                        m_tlast
);

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WI_W = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;
  localparam int WW   = fjd_pkg::WORKER_W;
  localparam int TW   = fjd_pkg::TIME_W;
  localparam int DW   = fjd_pkg::DUR_W;
  localparam int SW   = fjd_pkg::TOTAL_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FREE   = 4'b0010,
    S_ASSIGN = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  // job store, read port always tracks the next head
  fjd_pkg::job_t jobs [QUEUE_DEPTH];
  fjd_pkg::job_t head_job;
  logic          mem_we;

  logic [QA_W-1:0] head, head_next, tail, tail_next;
  logic [QC_W-1:0] count, count_next;

  logic [WW-1:0] free_stack [WORKER_COUNT];
  logic [WW-1:0] free_stack_next [WORKER_COUNT];
  logic [WW-1:0] free_cnt, free_cnt_next;

  logic          busy [WORKER_COUNT];
  logic          busy_next [WORKER_COUNT];
  logic [TW-1:0] wstart [WORKER_COUNT];
  logic [TW-1:0] wstart_next [WORKER_COUNT];
  logic [DW-1:0] wdur [WORKER_COUNT];
  logic [DW-1:0] wdur_next [WORKER_COUNT];
  logic [SW-1:0] wtotal [WORKER_COUNT];
  logic [SW-1:0] wtotal_next [WORKER_COUNT];

  logic [TW-1:0]   cur_time, cur_time_next;
  state_t          state, state_next;
  logic [WW-1:0]   n_assigned, n_assigned_next;
  logic [WW-1:0]   rep_w, rep_w_next;
  logic            pend_valid, pend_valid_next;
  fjd_pkg::result_t pend, pend_next;

  logic             out_valid;
  fjd_pkg::result_t out_reg;
  logic             out_free;
  logic             out_load;
  fjd_pkg::result_t out_val;

  // assignment datapath
  logic [WW-1:0]   top_pos;
  logic [WW-1:0]   wk;
  logic [WW-1:0]   wk_m1;
  logic [WI_W-1:0] widx;
  logic            can_assign;
  logic [SW:0]     sum;
  logic [WW-1:0]   rep_m1;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.data;
  assign m_tuser  = out_reg.kind;
  assign m_tlast  = out_reg.last;

  assign top_pos    = free_cnt - 3'd1;
  assign wk         = free_stack[top_pos[WI_W-1:0]];
  assign wk_m1      = wk - 3'd1;
  assign widx       = wk_m1[WI_W-1:0];
  assign can_assign = (count != '0) && (free_cnt != '0) &&
                      (n_assigned < WW'(WORKER_COUNT)) &&
                      (head_job.arrival_time <= cur_time);
  assign sum        = {1'b0, wtotal[widx]} + (SW + 1)'(head_job.service_time);
  assign rep_m1     = rep_w - 3'd1;

  always_comb begin
    logic [WW-1:0] cnt;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    free_stack_next = free_stack;
    free_cnt_next   = free_cnt;
    busy_next       = busy;
    wstart_next     = wstart;
    wdur_next       = wdur;
    wtotal_next     = wtotal;
    cur_time_next   = cur_time;
    state_next      = state;
    n_assigned_next = n_assigned;
    rep_w_next      = rep_w;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_load        = 1'b0;
    out_val         = '0;
    cnt             = free_cnt;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            fjd_pkg::ACT_ENQUEUE: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                out_load  = 1'b1;
                out_val.kind = fjd_pkg::KIND_STATUS;
                out_val.last = 1'b1;
                if (count != QC_W'(QUEUE_DEPTH)) begin
                  mem_we     = 1'b1;
                  tail_next  = (tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
                  count_next = count + 1'b1;
                  out_val.data.accepted = 1'b1;
                end
              end
            end
            fjd_pkg::ACT_TICK: begin
              cmd_ready       = 1'b1;
              n_assigned_next = '0;
              state_next      = S_FREE;
            end
            fjd_pkg::ACT_REPORT: begin
              cmd_ready  = 1'b1;
              rep_w_next = WW'(WORKER_COUNT);
              state_next = S_REPORT;
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end

      S_FREE: begin
        // release finished workers in worker order, pushing each on the stack
        for (int w = 0; w < WORKER_COUNT; w++) begin
          if (busy[w] && ((cur_time - wstart[w]) == TW'(wdur[w])) &&
              (cnt < WW'(WORKER_COUNT))) begin
            busy_next[w]   = 1'b0;
            wstart_next[w] = '0;
            wdur_next[w]   = '0;
            free_stack_next[cnt[WI_W-1:0]] = WW'(w + 1);
            cnt = cnt + 3'd1;
          end
        end
        free_cnt_next = cnt;
        state_next    = S_ASSIGN;
      end

      S_ASSIGN: begin
        // the held result goes out once we know whether another follows
        if (can_assign) begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_load     = 1'b1;
              out_val      = pend;
              out_val.last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = '0;
            pend_next.kind  = fjd_pkg::KIND_ASSIGN;
            pend_next.data.out_job_id    = head_job.job_id;
            pend_next.data.worker_number = wk;
            pend_next.data.start_time    = cur_time;
            pend_next.data.end_time      = {1'b0, cur_time} +
                                           fjd_pkg::END_W'(head_job.service_time);
            pend_next.data.wait_time     = cur_time - head_job.arrival_time;
            head_next       = (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count_next      = count - 1'b1;
            free_cnt_next   = free_cnt - 3'd1;
            busy_next[widx]   = 1'b1;
            wstart_next[widx] = cur_time;
            wdur_next[widx]   = head_job.service_time;
            wtotal_next[widx] = sum[SW] ? fjd_pkg::TOTAL_MAX : sum[SW-1:0];
            n_assigned_next = n_assigned + 3'd1;
          end
        end else if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_load     = 1'b1;
            out_val      = pend;
            out_val.last = 1'b1;
          end
          pend_valid_next = 1'b0;
          cur_time_next   = (cur_time == fjd_pkg::TIME_MAX) ? cur_time : cur_time + 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_REPORT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_val.kind = fjd_pkg::KIND_TOTAL;
          out_val.last = (rep_w == 3'd1);
          out_val.data.worker_number = rep_w;
          out_val.data.total_service = wtotal[rep_m1[WI_W-1:0]];
          rep_w_next = rep_m1;
          if (rep_w == 3'd1) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      jobs[tail] <= cmd.job;
    end
    head_job <= jobs[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      free_cnt   <= WW'(WORKER_COUNT);
      cur_time   <= TW'(1);
      state      <= S_IDLE;
      n_assigned <= '0;
      rep_w      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int w = 0; w < WORKER_COUNT; w++) begin
        free_stack[w] <= WW'(w + 1);
        busy[w]       <= 1'b0;
        wstart[w]     <= '0;
        wdur[w]       <= '0;
        wtotal[w]     <= '0;
      end
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      free_cnt   <= free_cnt_next;
      cur_time   <= cur_time_next;
      state      <= state_next;
      n_assigned <= n_assigned_next;
      rep_w      <= rep_w_next;
      pend_valid <= pend_valid_next;
      free_stack <= free_stack_next;
      busy       <= busy_next;
      wstart     <= wstart_next;
      wdur       <= wdur_next;
      wtotal     <= wtotal_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (out_load) begin
      out_reg <= out_val;
    end
  end

endmodule

// ----- sv/fifo_job_dispatch_to_worker_pool.sv -----
// Top level of the FIFO job dispatcher with a pool of workers.
// Instantiates fjd_front and fjd_back; types and codes come from fjd_pkg.
//
// Channel   Dir  Payload                                        Marks
// --------  ---  ---------------------------------------------  ---------------------------
// s_*       in   tdata: job_id, arrival_time, service_time      tuser: action
// m_*       out  tdata: accepted, out_job_id, worker_number,    tuser: kind, tlast: last
//                start_time, end_time, wait_time, total_service  result of a transaction
//
// Sequence: an enqueue is handled in the idle state once the output register is free.
// A tick frees finished workers in one pass, then makes one assignment per cycle while
// the output is not stalled (the job store's single read port sets this rate), then
// closes and advances time. A report gives each worker's total, highest worker first.
// Reset (rst, synchronous) empties both queues, stacks workers 1..WORKER_COUNT and
// sets time to 1; no clearing pass. Either side may stall: a two-entry command queue
// and the output register decouple input from output.
module fifo_job_dispatch_to_worker_pool #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int WORKER_COUNT = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [79:0]                   s_tdata,   // job_id, arrival_time, service_time
  input  logic [fjd_pkg::ACTION_W-1:0]  s_tuser,   // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [183:0]                  m_tdata,   // accepted, out_job_id, worker_number,
                                                   // start_time, end_time, wait_time,
                                                   // total_service
  output logic [fjd_pkg::KIND_W-1:0]    m_tuser,   // kind
  output logic                          m_tlast
);

  // commands between front and back
  logic          cmd_valid;
  logic          cmd_ready;
  fjd_pkg::cmd_t cmd;

  fjd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  fjd_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .WORKER_COUNT (WORKER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- sv/fjd_checker.sv -----
// Port-level checks for the job dispatcher, bound to the top level.
// Depends on fjd_pkg and fifo_job_dispatch_to_worker_pool.
module fjd_checker #(
  parameter int WORKER_COUNT = 6
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [183:0]                m_tdata,
  input logic [fjd_pkg::KIND_W-1:0]  m_tuser,
  input logic                        m_tlast
);

  fjd_pkg::out_data_t od;
  assign od = m_tdata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fjd_pkg::KIND_STATUS) |-> m_tlast && (od.worker_number == 3'd0))
    else $error("enqueue status not single and last");

  a_assign_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fjd_pkg::KIND_ASSIGN) |->
      (od.worker_number != 3'd0) &&
      (od.worker_number <= fjd_pkg::WORKER_W'(WORKER_COUNT)) &&
      (od.end_time >= {1'b0, od.start_time}))
    else $error("bad assignment fields");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fjd_pkg::KIND_TOTAL) |-> (m_tlast == (od.worker_number == 3'd1)))
    else $error("report last flag misplaced");

  a_total_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tuser == fjd_pkg::KIND_TOTAL) && !m_tlast |=>
      !m_tvalid || ((m_tuser == fjd_pkg::KIND_TOTAL) &&
                    (od.worker_number == $past(od.worker_number) - 3'd1)))
    else $error("report out of worker order");

endmodule

bind fifo_job_dispatch_to_worker_pool fjd_checker #(
  .WORKER_COUNT (WORKER_COUNT)
) u_fjd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
